/* rtl/nau_pkg.sv */
// ----------------------------------------------------------------------------
// nau_pkg
// shared types and constants of the neural activation unit
// ----------------------------------------------------------------------------
package nau_pkg;

	// default parameter values
	localparam int TABLE_SEGMENTS_DEF = 64;
	localparam int DATA_WIDTH_DEF     = 16;

	// fixed widths of the Q4.12 datapath
	localparam int SLOPE_W   = 13;
	localparam int SIG_W     = 13;
	localparam int TBL_ARG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [SLOPE_W-1:0]   ONE_Q12    = 13'd4096;
	localparam logic [CFG_DAT_W-1:0] LEAK_RESET = 16'd66;

	// activation function selection
	typedef enum logic [2:0] {
		MODE_LINEAR  = 3'd0,
		MODE_RELU    = 3'd1,
		MODE_LEAKY   = 3'd2,
		MODE_SIGMOID = 3'd3,
		MODE_TANH    = 3'd4
	} act_mode_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAK = 2'd1;

	// per-stage load enables handed to the table interpolator
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

/* rtl/nau_sig_interp.sv */
// ----------------------------------------------------------------------------
// nau_sig_interp
// three-stage sigmoid table lookup with linear interpolation
// ----------------------------------------------------------------------------
module nau_sig_interp #(
	parameter int TABLE_SEGMENTS = nau_pkg::TABLE_SEGMENTS_DEF
) (
	input  logic                             clk,
	input  nau_pkg::stage_en_t               en,
	input  logic [nau_pkg::TBL_ARG_W-1:0]    arg_s1,
	output logic [nau_pkg::SIG_W-1:0]        sig_s4
);

	localparam int IW = $clog2(TABLE_SEGMENTS + 1);
	localparam int PW = nau_pkg::TBL_ARG_W + IW;
	localparam int FW = nau_pkg::TBL_ARG_W;
	localparam int SW = nau_pkg::SIG_W;
	localparam longint unsigned Q30_ONE = 64'd1 << 30;

	// quotient by restoring long division, divisor well below 2^63
	function automatic longint unsigned udiv_q(input longint unsigned n,
			input longint unsigned dv);
		longint unsigned q;
		longint unsigned r;
		int              b;
		q = 64'd0;
		r = 64'd0;
		for (b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= dv) begin
				r    = r - dv;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^-f for f in Q30, 0 <= f <= 1.0, alternating series
	function automatic longint unsigned exp_series_q30(input longint unsigned f);
		longint unsigned term;
		longint unsigned sum;
		longint unsigned i;
		term = Q30_ONE;
		sum  = Q30_ONE;
		for (i = 1; i <= 24; i++) begin
			term = udiv_q((term * f) >> 30, i);
			if (i[0]) begin
				sum = (term > sum) ? 64'd0 : sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	// e^-t for t in Q30, 0 <= t <= 8.0
	function automatic longint unsigned exp_neg_q30(input longint unsigned t);
		longint unsigned whole;
		longint unsigned r;
		longint unsigned e1;
		longint unsigned i;
		whole = t >> 30;
		r     = exp_series_q30(t & (Q30_ONE - 64'd1));
		e1    = exp_series_q30(Q30_ONE);
		for (i = 0; i < whole && i < 16; i++) begin
			r = (r * e1) >> 30;
		end
		return r;
	endfunction

	// sigmoid at segment endpoint k, rounded to Q12
	function automatic logic [SW-1:0] rom_entry(input int k);
		longint          a;
		longint unsigned mag;
		longint unsigned t;
		longint unsigned d;
		longint unsigned s;
		a   = 16 * longint'(k) - 8 * longint'(TABLE_SEGMENTS);
		mag = (a < 0) ? unsigned'(-a) : unsigned'(a);
		t   = udiv_q(mag << 30, 64'(TABLE_SEGMENTS));
		d   = Q30_ONE + exp_neg_q30(t);
		s   = udiv_q((64'd1 << 42) + (d >> 1), d);
		if (s > 64'd4096) begin
			s = 64'd4096;
		end
		if (a < 0) begin
			s = 64'd4096 - s;
		end
		return s[SW-1:0];
	endfunction

	logic [SW-1:0] rom [TABLE_SEGMENTS+1];

	for (genvar k = 0; k <= TABLE_SEGMENTS; k++) begin : g_rom
		localparam logic [SW-1:0] ENTRY = rom_entry(k);
		assign rom[k] = ENTRY;
	end

	// stage 2: segment and fraction
	logic [PW-1:0] pos;
	logic [IW-1:0] seg_s2;
	logic [FW-1:0] frac_s2;

	assign pos = PW'(arg_s1) * PW'(TABLE_SEGMENTS);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			seg_s2  <= pos[PW-1:FW];
			frac_s2 <= pos[FW-1:0];
		end
	end

	// stage 3: endpoint lookup
	logic [IW-1:0] seg_next;
	logic [SW-1:0] y0;
	logic [SW-1:0] y1;
	logic [SW-1:0] y0_s3;
	logic [SW-1:0] dy_s3;
	logic [FW-1:0] frac_s3;

	assign seg_next = seg_s2 + IW'(1);
	assign y0       = rom[seg_s2];
	assign y1       = rom[seg_next];

	always_ff @(posedge clk) begin
		if (en.s3) begin
			y0_s3   <= y0;
			dy_s3   <= (y1 < y0) ? '0 : y1 - y0;
			frac_s3 <= frac_s2;
		end
	end

	// stage 4: interpolation
	logic [SW+FW-1:0] step;

	assign step = (SW + FW)'(dy_s3) * (SW + FW)'(frac_s3);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			sig_s4 <= y0_s3 + step[SW+FW-1:FW];
		end
	end

endmodule

/* rtl/neural_activation_unit.sv */
// ----------------------------------------------------------------------------
// neural_activation_unit
// linear, relu, leaky relu, sigmoid and tanh with derivative, Q4.12
// ----------------------------------------------------------------------------
// an accepted input word passes through register stages s1 to s5 to its output word
// throughput: one word per cycle, stalls only when the output is not taken
// five register stages, each holding at most one word; bubbles are squeezed out
// reset: asynchronous, clears all valid bits, mode to linear, leak slope to 66
// the sigmoid table is constant logic and needs no fill after reset
// ----------------------------------------------------------------------------
module neural_activation_unit #(
	parameter int TABLE_SEGMENTS = nau_pkg::TABLE_SEGMENTS_DEF,
	parameter int DATA_WIDTH     = nau_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nau_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nau_pkg::CFG_DAT_W-1:0]     cfg_data,
	// input word
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [DATA_WIDTH-1:0]      pre_activation,
	// output word
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [DATA_WIDTH-1:0]      activation,
	output logic [nau_pkg::SLOPE_W-1:0]       slope
);

	localparam int DW = DATA_WIDTH;
	localparam int SW = nau_pkg::SIG_W;
	localparam int LW = nau_pkg::CFG_DAT_W;
	// argument width: room for the doubled input and the table bounds
	localparam int XW = (DW + 2 > 18) ? DW + 2 : 18;
	localparam int PW = DW + LW + 1;
	localparam logic signed [XW-1:0] ARG_MIN = XW'(-32768);
	localparam logic signed [XW-1:0] ARG_MAX = XW'(32767);

	// ------------------------------------------------------------------
	// configuration registers, always ready
	// ------------------------------------------------------------------
	logic [2:0]    mode_q;
	logic [LW-1:0] leak_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= nau_pkg::MODE_LINEAR;
			leak_q <= nau_pkg::LEAK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == nau_pkg::CFG_MODE) begin
				mode_q <= cfg_data[2:0];
			end else if (cfg_index == nau_pkg::CFG_LEAK) begin
				leak_q <= cfg_data;
			end
		end
	end

	// ------------------------------------------------------------------
	// stall chain: a stage loads when it is empty or its successor loads
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	nau_pkg::stage_en_t tbl_en;

	assign en_s5    = !valid_s5 || out_ready;
	assign en_s4    = !valid_s4 || en_s5;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;
	assign tbl_en   = '{s2: en_s2, s3: en_s3, s4: en_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: table argument and leaky product
	// ------------------------------------------------------------------
	logic signed [XW-1:0] x_ext;
	logic signed [XW-1:0] arg;
	logic signed [XW-1:0] arg_clamp;
	logic signed [PW-1:0] leak_prod;

	assign x_ext = XW'(pre_activation);
	// tanh looks up sigmoid at twice the input
	assign arg   = (mode_q == nau_pkg::MODE_TANH) ? (x_ext <<< 1) : x_ext;

	always_comb begin
		if (arg < ARG_MIN) begin
			arg_clamp = ARG_MIN;
		end else if (arg > ARG_MAX) begin
			arg_clamp = ARG_MAX;
		end else begin
			arg_clamp = arg;
		end
	end

	assign leak_prod = pre_activation * $signed({1'b0, leak_q});

	logic signed [DW-1:0]             x_s1;
	logic signed [PW-1:0]             leak_prod_s1;
	logic [LW-5:0]                    leak_slope_s1;
	logic [2:0]                       mode_s1;
	logic [nau_pkg::TBL_ARG_W-1:0]    tbl_arg_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1          <= pre_activation;
			leak_prod_s1  <= leak_prod;
			leak_slope_s1 <= leak_q[LW-1:4];
			mode_s1       <= mode_q;
			// offset binary: table argument 0 is the low end of the range
			tbl_arg_s1    <= arg_clamp[15:0] ^ 16'h8000;
		end
	end

	// ------------------------------------------------------------------
	// stages 2-4: sigmoid table interpolation
	// ------------------------------------------------------------------
	logic [SW-1:0] sig_s4;

	nau_sig_interp #(
		.TABLE_SEGMENTS(TABLE_SEGMENTS)
	) u_sig_interp (
		.clk   (clk),
		.en    (tbl_en),
		.arg_s1(tbl_arg_s1),
		.sig_s4(sig_s4)
	);

	// ------------------------------------------------------------------
	// stage 2: piecewise-linear modes, carried alongside the table
	// ------------------------------------------------------------------
	logic                          x_pos;
	logic signed [DW-1:0]          act_lin;
	logic [nau_pkg::SLOPE_W-1:0]   slope_lin;

	assign x_pos = !x_s1[DW-1] && (|x_s1);

	always_comb begin
		unique case (mode_s1)
			nau_pkg::MODE_LINEAR: begin
				act_lin   = x_s1;
				slope_lin = nau_pkg::ONE_Q12;
			end
			nau_pkg::MODE_RELU: begin
				act_lin   = x_pos ? x_s1 : '0;
				slope_lin = x_pos ? nau_pkg::ONE_Q12 : '0;
			end
			nau_pkg::MODE_LEAKY: begin
				// arithmetic shift of the signed product floors toward minus infinity
				act_lin   = x_pos ? x_s1 : leak_prod_s1[DW+15:16];
				slope_lin = x_pos ? nau_pkg::ONE_Q12 : {1'b0, leak_slope_s1};
			end
			nau_pkg::MODE_SIGMOID, nau_pkg::MODE_TANH: begin
				// filled in at the last stage
				act_lin   = '0;
				slope_lin = '0;
			end
			default: begin
				act_lin   = '0;
				slope_lin = '0;
			end
		endcase
	end

	logic signed [DW-1:0]          act_s2, act_s3, act_s4;
	logic [nau_pkg::SLOPE_W-1:0]   slope_s2, slope_s3, slope_s4;
	logic [2:0]                    mode_s2, mode_s3, mode_s4;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			act_s2   <= act_lin;
			slope_s2 <= slope_lin;
			mode_s2  <= mode_s1;
		end
		if (en_s3) begin
			act_s3   <= act_s2;
			slope_s3 <= slope_s2;
			mode_s3  <= mode_s2;
		end
		if (en_s4) begin
			act_s4   <= act_s3;
			slope_s4 <= slope_s3;
			mode_s4  <= mode_s3;
		end
	end

	// ------------------------------------------------------------------
	// stage 5: output register, derivative for sigmoid and tanh
	// ------------------------------------------------------------------
	logic                          is_tanh;
	logic signed [SW:0]            tanh_val;
	logic [SW-1:0]                 tanh_mag;
	logic [SW-1:0]                 mul_a;
	logic [SW-1:0]                 mul_b;
	logic [2*SW-1:0]               mul_p;
	logic signed [DW-1:0]          act_nxt;
	logic [nau_pkg::SLOPE_W-1:0]   slope_nxt;

	assign is_tanh  = (mode_s4 == nau_pkg::MODE_TANH);
	// tanh = 2 * sigmoid(2x) - 1
	assign tanh_val = $signed({sig_s4, 1'b0}) - $signed((SW + 1)'(4096));
	assign tanh_mag = tanh_val[SW] ? SW'(-tanh_val) : tanh_val[SW-1:0];

	// one multiplier: s * (1 - s) for sigmoid, t * t for tanh
	assign mul_a = is_tanh ? tanh_mag : sig_s4;
	assign mul_b = is_tanh ? tanh_mag : nau_pkg::ONE_Q12 - sig_s4;
	assign mul_p = (2 * SW)'(mul_a) * (2 * SW)'(mul_b);

	always_comb begin
		priority if (mode_s4 == nau_pkg::MODE_SIGMOID) begin
			act_nxt   = DW'($signed({1'b0, sig_s4}));
			slope_nxt = mul_p[SW+11:12];
		end else if (is_tanh) begin
			act_nxt   = DW'(tanh_val);
			slope_nxt = nau_pkg::ONE_Q12 - mul_p[SW+11:12];
		end else begin
			act_nxt   = act_s4;
			slope_nxt = slope_s4;
		end
	end

	logic signed [DW-1:0]          act_s5;
	logic [nau_pkg::SLOPE_W-1:0]   slope_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			act_s5   <= act_nxt;
			slope_s5 <= slope_nxt;
		end
	end

	assign out_valid  = valid_s5;
	assign activation = act_s5;
	assign slope      = slope_s5;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// an empty output register never holds back the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s5 |-> in_ready)
		else $error("input stalled with empty output register");

	// a full pipeline with a stalled output takes no new word
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && !out_ready)
		|-> !in_ready)
		else $error("word accepted into a full pipeline");

	// derivative never exceeds one
	a_slope_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (slope <= nau_pkg::ONE_Q12))
		else $error("slope above 1.0");

	// a word taken from the output leaves its stage unless a new one arrives
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !valid_s4) |=> !out_valid)
		else $error("output word repeated");

endmodule
